// ===== design/plq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plq_pkg: shared types and constants of the price level order queue
// Command codes, word types, the stored order record and controller states.
// ---------------------------------------------------------------------------
package plq_pkg;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    CmdInsert = 3'd0,
    CmdTrade  = 3'd1,
    CmdCancel = 3'd2,
    CmdChange = 3'd3,
    CmdMove   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] order_id;
    logic [31:0] account;
    logic [31:0] price;
    logic [31:0] volume;
    logic [31:0] client_id;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] out_account;
    logic [31:0] out_price;
    logic [31:0] out_volume;
    logic [31:0] out_id;
    logic [31:0] out_client_id;
    logic [6:0]  entry_count;
    logic        head_valid;
    logic [31:0] head_id;
    logic [31:0] head_volume;
  } out_word_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] account;
    logic [31:0] price;
    logic [31:0] volume;
    logic [31:0] client;
  } order_t;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StShift,
    StHead,
    StDone
  } state_e;

endpackage

// ===== design/plq_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plq_ram: order slot memory
// One write port, one registered read port.
// ---------------------------------------------------------------------------
module plq_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 160
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== design/price_level_order_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// price_level_order_queue: time-priority queue of one price level
// Orders live in a slot memory in arrival order, slot 0 is the head.
// ---------------------------------------------------------------------------
//  channel | ports                     | handshake
//  command | start_i, cmd_word_i       | taken when start_i and !busy_o
//  result  | done_o, res_word_o        | one cycle strobe, cannot be held off
//
// After acceptance an insert writes its slot if there is room. On an empty
// queue a trade or search goes straight to the result; else the scan walks
// to the match or the last slot, a change or partial head trade rewrites
// that slot, a removal shifts the later slots forward one per cycle through
// the single memory port. Every other path ends with a read of the head.
// Reset clears the count and control only; the memory holds no reset.
// busy_o drops in the strobe cycle, so the next word may be taken there.
// ---------------------------------------------------------------------------
module price_level_order_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  plq_pkg::in_word_t cmd_word_i,
  output logic              busy_o,
  output logic              done_o,
  output plq_pkg::out_word_t res_word_o
);
  import plq_pkg::*;

  state_e state_q, state_d;
  in_word_t cmd_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] ptr_q, ptr_d;   // scan / shift pointer
  logic            ok_q, ok_d;
  order_t          rep_q, rep_d;   // reported order
  logic            rd_pend_q, rd_pend_d; // read data valid this cycle
  out_word_t       res_q;
  logic            done_q;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  order_t          wdata, rdata;

  plq_ram #(.Depth(QueueDepth), .Width($bits(order_t))) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic accept;
  assign accept = start_i && (state_q == StIdle);
  assign busy_o = (state_q != StIdle);

  logic [31:0] traded;
  assign traded = (rdata.volume >= cmd_q.volume) ? cmd_q.volume : rdata.volume;

  // next state and datapath
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    ok_d      = ok_q;
    rep_d     = rep_q;
    rd_pend_d = 1'b0;
    we        = 1'b0;
    waddr     = ptr_q[IdxW-1:0];
    wdata     = rdata;
    raddr     = ptr_q[IdxW-1:0];
    case (state_q)
      StIdle: begin
        if (accept) begin
          ok_d  = 1'b0;
          rep_d = '0;
          ptr_d = '0;
          raddr = '0;
          case (cmd_word_i.cmd)
            CmdInsert: begin
              if (count_q < CntW'(QueueDepth)) begin
                we      = 1'b1;
                waddr   = count_q[IdxW-1:0];
                wdata   = '{cmd_word_i.order_id, cmd_word_i.account,
                            cmd_word_i.price, cmd_word_i.volume, cmd_word_i.client_id};
                count_d = count_q + 1'b1;
                ok_d    = 1'b1;
              end
              state_d = StHead;
            end
            CmdTrade, CmdCancel, CmdChange, CmdMove: begin
              if (count_q != '0) begin
                rd_pend_d = 1'b1;
                state_d   = StScan;
              end else begin
                state_d = StDone;
              end
            end
            // undefined code: state untouched, head still reported
            default: state_d = StHead;
          endcase
        end
      end
      StScan: begin
        // rdata holds slot ptr_q
        if (cmd_q.cmd == CmdTrade) begin
          ok_d  = 1'b1;
          rep_d = '{rdata.id, rdata.account, rdata.price, traded, rdata.client};
          if (rdata.volume == traded) begin
            ptr_d     = '0;
            raddr     = IdxW'(1);
            rd_pend_d = 1'b1;
            state_d   = (count_q > CntW'(1)) ? StShift : StHead;
            if (count_q == CntW'(1)) count_d = '0;
          end else begin
            we      = 1'b1;
            waddr   = '0;
            wdata   = rdata;
            wdata.volume = rdata.volume - traded;
            state_d = StHead;
          end
        end else if (rdata.id == cmd_q.order_id) begin
          ok_d = 1'b1;
          if (cmd_q.cmd == CmdChange) begin
            we      = 1'b1;
            wdata   = rdata;
            wdata.volume = cmd_q.volume;
            state_d = StHead;
          end else begin
            if (cmd_q.cmd == CmdMove) rep_d = rdata;
            if (ptr_q + 1'b1 < count_q) begin
              raddr     = IdxW'(ptr_q + 1'b1);
              rd_pend_d = 1'b1;
              state_d   = StShift;
            end else begin
              count_d = count_q - 1'b1;
              state_d = StHead;
            end
          end
        end else if (ptr_q + 1'b1 < count_q) begin
          ptr_d     = ptr_q + 1'b1;
          raddr     = IdxW'(ptr_q + 1'b1);
          rd_pend_d = 1'b1;
        end else begin
          state_d = StHead;
        end
      end
      StShift: begin
        // rdata holds slot ptr_q+1: move it to ptr_q
        we    = 1'b1;
        waddr = ptr_q[IdxW-1:0];
        wdata = rdata;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q + CntW'(2) < count_q) begin
          raddr     = IdxW'(ptr_q + CntW'(2));
          rd_pend_d = 1'b1;
        end else begin
          count_d = count_q - 1'b1;
          state_d = StHead;
        end
      end
      StHead: begin
        raddr     = '0;
        rd_pend_d = 1'b1;
        state_d   = StDone;
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // result word
  out_word_t res_d;
  always_comb begin
    res_d               = '0;
    res_d.ok            = ok_q;
    res_d.entry_count   = 7'(count_q);
    if (ok_q && (cmd_q.cmd == CmdTrade || cmd_q.cmd == CmdMove)) begin
      res_d.out_account   = rep_q.account;
      res_d.out_price     = rep_q.price;
      res_d.out_volume    = rep_q.volume;
      res_d.out_id        = rep_q.id;
      res_d.out_client_id = rep_q.client;
    end
    if (count_q != '0 && rd_pend_q) begin
      res_d.head_valid  = 1'b1;
      res_d.head_id     = rdata.id;
      res_d.head_volume = rdata.volume;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      ptr_q     <= '0;
      ok_q      <= 1'b0;
      rd_pend_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      ok_q      <= ok_d;
      rd_pend_q <= rd_pend_d;
      done_q    <= (state_q == StDone);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) cmd_q <= cmd_word_i;
    rep_q <= rep_d;
    if (state_q == StDone) res_q <= res_d;
  end

  assign done_o     = done_q;
  assign res_word_o = res_q;
endmodule

// ===== design/plq_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plq_checker: port-level checks of the price level order queue
// Bound to the top level.
// ---------------------------------------------------------------------------
module plq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input plq_pkg::out_word_t res_word_o
);
  import plq_pkg::*;

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("no busy after start");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double strobe");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_word_o.entry_count <= 7'(QueueDepth)) else $error("count");
  a_head_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_word_o.head_valid == (res_word_o.entry_count != 7'd0)))
    else $error("head flag");
endmodule

bind price_level_order_queue plq_checker u_plq_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .done_o(done_o), .res_word_o(res_word_o)
);

// ===== test/price_level_order_queue_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// price_level_order_queue_test: self-checking bench for the order queue
// Commands go in from a queue of pending words through a clocked driver. A
// clocked monitor checks each result word against a local price-level model.
// ---------------------------------------------------------------------------
module price_level_order_queue_test;
  import plq_pkg::*;

  localparam int Depth = QueueDepth;
  localparam int NumRandom = 468;

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  in_word_t   cmd_word_i;
  logic       busy_o;
  logic       done_o;
  out_word_t  res_word_o;

  price_level_order_queue i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .cmd_word_i (cmd_word_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .res_word_o (res_word_o)
  );

  // Local copy of the price level: slot 0 is the head.
  order_t    book_slots[Depth];
  int        book_fill;

  in_word_t  pending_words[$];
  out_word_t expected_results[$];
  int        idle_pct;
  bit        hold_sender;
  int        error_count;
  int        result_count;
  int        accept_count;
  int        ok_count;
  int        full_reject_count;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Drop the order at pos and close the gap behind it.
  function automatic void book_remove(int pos);
    for (int i = pos; i < book_fill - 1; i++) book_slots[i] = book_slots[i + 1];
    book_fill--;
  endfunction

  function automatic int book_find(logic [31:0] id);
    for (int i = 0; i < book_fill; i++) if (book_slots[i].id == id) return i;
    return -1;
  endfunction

  // Apply one command to the local book and return the result word.
  function automatic out_word_t book_apply(in_word_t w);
    out_word_t   r;
    int          pos;
    logic [31:0] traded;
    r = '0;
    case (w.cmd)
      CmdInsert: begin
        if (book_fill < Depth) begin
          book_slots[book_fill] = '{w.order_id, w.account, w.price, w.volume, w.client_id};
          book_fill++;
          r.ok = 1'b1;
        end else begin
          full_reject_count++;
        end
      end
      CmdTrade: begin
        if (book_fill > 0) begin
          traded = (book_slots[0].volume >= w.volume) ? w.volume : book_slots[0].volume;
          book_slots[0].volume -= traded;
          r.ok = 1'b1;
          r.out_account = book_slots[0].account;
          r.out_price = book_slots[0].price;
          r.out_volume = traded;
          r.out_id = book_slots[0].id;
          r.out_client_id = book_slots[0].client;
          if (book_slots[0].volume == 0) book_remove(0);
        end
      end
      CmdCancel: begin
        pos = book_find(w.order_id);
        if (pos >= 0) begin
          book_remove(pos);
          r.ok = 1'b1;
        end
      end
      CmdChange: begin
        pos = book_find(w.order_id);
        if (pos >= 0) begin
          book_slots[pos].volume = w.volume;
          r.ok = 1'b1;
        end
      end
      CmdMove: begin
        pos = book_find(w.order_id);
        if (pos >= 0) begin
          r.ok = 1'b1;
          r.out_account = book_slots[pos].account;
          r.out_price = book_slots[pos].price;
          r.out_volume = book_slots[pos].volume;
          r.out_id = book_slots[pos].id;
          r.out_client_id = book_slots[pos].client;
          book_remove(pos);
        end
      end
      default: ;
    endcase
    r.entry_count = 7'(book_fill);
    if (book_fill > 0) begin
      r.head_valid = 1'b1;
      r.head_id = book_slots[0].id;
      r.head_volume = book_slots[0].volume;
    end
    return r;
  endfunction

  function automatic in_word_t make_word(cmd_e c, logic [31:0] id, logic [31:0] vol);
    in_word_t w;
    w.cmd = c;
    w.order_id = id;
    w.account = $urandom;
    w.price = $urandom;
    w.volume = vol;
    w.client_id = $urandom;
    return w;
  endfunction

  // Random volume: mostly small so trades drain orders, sometimes extreme.
  function automatic logic [31:0] pick_volume();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  // Driver: hold start until the word is taken; one nonblocking write per step.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i    <= 1'b0;
      cmd_word_i <= '0;
    end else if (start_i && busy_o) begin
      // word still waiting for acceptance
    end else begin
      if (start_i) begin
        expected_results.push_back(book_apply(cmd_word_i));
        accept_count++;
      end
      if (pending_words.size() > 0 && !hold_sender &&
          $urandom_range(0, 99) >= idle_pct) begin
        start_i    <= 1'b1;
        cmd_word_i <= pending_words.pop_front();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: every strobe must match the oldest expectation field by field.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      result_count++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word, actual %p", $time, res_word_o);
        error_count++;
      end else begin
        out_word_t e;
        e = expected_results.pop_front();
        if (e.ok) ok_count++;
        if (res_word_o !== e) begin
          $display("%0t: mismatch, expected %p", $time, e);
          $display("%0t:           actual   %p", $time, res_word_o);
          error_count++;
        end
      end
    end
  end

  task automatic drain_sender();
    while (pending_words.size() > 0 || start_i) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] ids_used[$];
    logic [31:0] id;
    int          n;
    rst_ni = 1'b0;
    idle_pct = 0;
    hold_sender = 1'b0;
    error_count = 0;
    result_count = 0;
    accept_count = 0;
    ok_count = 0;
    full_reject_count = 0;
    book_fill = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-queue cases, field extremes, zero trade, duplicates,
    // change to zero, unknown id and undefined command codes.
    pending_words.push_back(make_word(CmdTrade, 32'd0, 32'd5));
    pending_words.push_back(make_word(CmdCancel, 32'd1, 32'd0));
    pending_words.push_back(make_word(CmdMove, 32'd1, 32'd0));
    pending_words.push_back(make_word(CmdChange, 32'd1, 32'd3));
    pending_words.push_back('{CmdInsert, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF});
    pending_words.push_back('{CmdInsert, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    pending_words.push_back(make_word(CmdInsert, 32'd7, 32'd10));
    pending_words.push_back(make_word(CmdInsert, 32'd7, 32'd20));
    pending_words.push_back(make_word(CmdTrade, 32'd0, 32'd0));
    pending_words.push_back(make_word(CmdTrade, 32'd0, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(CmdTrade, 32'd0, 32'd0));
    pending_words.push_back(make_word(CmdChange, 32'd7, 32'd0));
    pending_words.push_back(make_word(CmdMove, 32'd7, 32'd0));
    pending_words.push_back(make_word(CmdCancel, 32'd7, 32'd0));
    pending_words.push_back(make_word(CmdCancel, 32'd99, 32'd0));
    pending_words.push_back(make_word(CmdTrade, 32'd0, 32'd4));
    begin
      in_word_t w;
      w = make_word(CmdInsert, 32'd5, 32'd5);
      w.cmd = 3'd7;
      pending_words.push_back(w);
      w.cmd = 3'd5;
      pending_words.push_back(w);
    end
    drain_sender();

    // Fill to the brim, then try two inserts past it.
    for (int i = 0; i < Depth + 2; i++)
      pending_words.push_back(make_word(CmdInsert, 32'(1000 + i), pick_volume()));
    pending_words.push_back(make_word(CmdMove, 32'(1000 + Depth - 1), 32'd0));
    pending_words.push_back(make_word(CmdCancel, 32'd1000, 32'd0));
    // Sender holds off for a pause, then the queued words are drained.
    hold_sender = 1'b1;
    repeat (40) @(posedge clk_i);
    hold_sender = 1'b0;
    drain_sender();
    for (int i = 0; i < Depth; i++) ids_used.push_back(32'(1000 + i));

    // Random phases: mostly inserts and searches for live ids.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 47;
        2: idle_pct = 6;
        default: idle_pct = 0;
      endcase
      n = NumRandom / 4;
      for (int k = 0; k < n; k++) begin
        int sel;
        sel = $urandom_range(0, 99);
        if (ids_used.size() == 0 || $urandom_range(0, 9) == 0)
          id = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 40));
        else
          id = ids_used[$urandom_range(0, ids_used.size() - 1)];
        if (sel < 35) begin
          pending_words.push_back(make_word(CmdInsert, id, pick_volume()));
          ids_used.push_back(id);
          if (ids_used.size() > 80) void'(ids_used.pop_front());
        end else if (sel < 55) begin
          pending_words.push_back(make_word(CmdTrade, $urandom, pick_volume()));
        end else if (sel < 68) begin
          pending_words.push_back(make_word(CmdCancel, id, $urandom));
        end else if (sel < 81) begin
          pending_words.push_back(make_word(CmdChange, id, pick_volume()));
        end else if (sel < 96) begin
          pending_words.push_back(make_word(CmdMove, id, $urandom));
        end else begin
          in_word_t w;
          w = make_word(CmdInsert, id, $urandom);
          w.cmd = 3'($urandom_range(5, 7));
          pending_words.push_back(w);
        end
      end
      drain_sender();
    end

    repeat (200) @(posedge clk_i);
    $display("Ran %0d commands, %0d results, %0d with ok set, %0d inserts refused as full.",
             accept_count, result_count, ok_count, full_reject_count);
    $display("Covered empty and full queue, zero and maximum volumes, duplicate ids.");
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/plq_pkg.sv
design/plq_ram.sv
design/price_level_order_queue.sv
design/plq_checker.sv
test/price_level_order_queue_test.sv
